[hdl/pocp_pkg.sv]
`timescale 1ns / 1ps

package pocp_pkg;

    // Field widths
    localparam int SampleW = 14;
    localparam int MagW    = 15;
    localparam int RmsW    = 12;
    localparam int FaultW  = 2;
    localparam int RmsLimW = 16;
    localparam int InstW   = 13;
    localparam int WinW    = 10;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 16;

    // Stream payload widths, padded to whole bytes
    localparam int InDataW  = 32;
    localparam int OutDataW = 40;

    // peak / 1.414 * 0.25 as a Q16 reciprocal
    localparam int                RmsShift = 16;
    localparam logic [13:0]       RMS_MUL  = 14'd11587;
    localparam logic [RmsW-1:0]   RMS_MAX  = 12'd4095;

    // Fault codes
    localparam logic [FaultW-1:0] FAULT_NONE    = 2'd0;
    localparam logic [FaultW-1:0] FAULT_RMS     = 2'd1;
    localparam logic [FaultW-1:0] FAULT_INSTANT = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_RMS_LIMIT     = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_INSTANT_LIMIT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_WINDOW        = 2'd2;

    // Configuration reset values
    localparam logic [RmsLimW-1:0] RMS_LIMIT_RST     = 16'd0;
    localparam logic [InstW-1:0]   INSTANT_LIMIT_RST = 13'd200;
    localparam logic [WinW-1:0]    WINDOW_RST        = 10'd300;

    typedef struct packed {
        logic                      motor_stopped;
        logic signed [SampleW-1:0] phase_w_mv;
        logic signed [SampleW-1:0] phase_u_mv;
    } sample_t;

    typedef struct packed {
        logic [MagW-1:0] abs_u;
        logic [MagW-1:0] abs_v;
        logic [MagW-1:0] abs_w;
        logic            instant_trip;
    } phase_t;

    typedef struct packed {
        logic [RmsW-1:0] rms_u;
        logic [RmsW-1:0] rms_v;
        logic [RmsW-1:0] rms_w;
        logic            updated;
        logic            rms_trip;
    } win_t;

    typedef struct packed {
        logic            rms_updated;
        logic [RmsW-1:0] rms_w;
        logic [RmsW-1:0] rms_v;
        logic [RmsW-1:0] rms_u;
        logic [FaultW-1:0] fault_code;
        logic            trip_now;
    } result_t;

    // Scale a peak to an rms estimate, saturating at full scale
    function automatic logic [RmsW-1:0] rms_of(input logic [MagW-1:0] peak);
        logic [MagW+13:0] prod;
        logic [MagW+13-RmsShift:0] scaled;
        prod   = peak * RMS_MUL;
        scaled = prod[MagW+13:RmsShift];
        if (scaled[MagW+13-RmsShift]) begin
            rms_of = RMS_MAX;
        end else begin
            rms_of = scaled[RmsW-1:0];
        end
    endfunction

endpackage

[hdl/phase_overcurrent_protector_unit.sv]
`timescale 1ns / 1ps

// Channel    | Dir | Ports                    | Payload
// -----------+-----+--------------------------+----------------------------------------
// sample in  | in  | s_axis_tvalid/tready/tdata | phase_u_mv, phase_w_mv, motor_stopped
// result out | out | m_axis_tvalid/tready/tdata | trip_now, fault_code, rms_u/v/w, updated
// config     | in  | cfg_we/cfg_index/cfg_wdata | rms_limit, instant_limit, window_samples
//
// One sample per cycle sustained while m_axis_tready stays high; a sample goes input
// register -> compute -> output register, so its result is offered on m_axis from the
// output register once the compute step has run, and a stall on m_axis holds it back.
// The compute step (offset subtract, abs, peak max, rms multiply, limit compare) is a
// single combinational pass that also updates all state in the same cycle.
// A stalled output holds its result; the input register still takes one more sample.
// aresetn (synchronous, active low) clears offsets, peaks, window count, rms values,
// the latched fault and the configuration registers to their defaults.

module phase_overcurrent_protector_unit (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [13:0] phase_u_mv, [27:14] phase_w_mv, [28] motor_stopped, [31:29] zero
    input  logic [pocp_pkg::InDataW-1:0]     s_axis_tdata,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] trip_now, [2:1] fault_code, [14:3] rms_u, [26:15] rms_v,
    // [38:27] rms_w, [39] rms_updated
    output logic [pocp_pkg::OutDataW-1:0]    m_axis_tdata,

    input  logic                             cfg_we,
    input  logic [pocp_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [pocp_pkg::CfgW-1:0]        cfg_wdata
);

    // Configuration registers
    logic [pocp_pkg::RmsLimW-1:0] rms_limit_reg;
    logic [pocp_pkg::InstW-1:0]   instant_limit_reg;
    logic [pocp_pkg::WinW-1:0]    window_reg;

    // Input register
    logic                         in_valid_reg, in_valid_next;
    pocp_pkg::sample_t            in_data_reg;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    pocp_pkg::result_t            out_data_reg, out_data_next;

    logic [pocp_pkg::FaultW-1:0]  fault_reg, fault_next;
    logic                         advance;
    logic                         in_xfer;
    pocp_pkg::phase_t             phase;
    pocp_pkg::win_t               win;

    // Write configuration; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rms_limit_reg     <= pocp_pkg::RMS_LIMIT_RST;
            instant_limit_reg <= pocp_pkg::INSTANT_LIMIT_RST;
            window_reg        <= pocp_pkg::WINDOW_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pocp_pkg::REG_RMS_LIMIT: begin
                    rms_limit_reg <= cfg_wdata;
                end
                pocp_pkg::REG_INSTANT_LIMIT: begin
                    instant_limit_reg <= cfg_wdata[pocp_pkg::InstW-1:0];
                end
                pocp_pkg::REG_WINDOW: begin
                    window_reg <= cfg_wdata[pocp_pkg::WinW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Advance when a sample waits and the output register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_data_reg <= pocp_pkg::sample_t'(s_axis_tdata[2*pocp_pkg::SampleW:0]);
        end
    end

    pocp_phase_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .sample        (in_data_reg),
        .instant_limit (instant_limit_reg),
        .phase         (phase)
    );

    pocp_window_rms u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .phase          (phase),
        .window_samples (window_reg),
        .rms_limit      (rms_limit_reg),
        .win            (win)
    );

    // Latch the fault; an rms trip in the same sample wins over an instant trip
    always_comb begin
        priority if (win.rms_trip) begin
            fault_next = pocp_pkg::FAULT_RMS;
        end else if (phase.instant_trip) begin
            fault_next = pocp_pkg::FAULT_INSTANT;
        end else begin
            fault_next = fault_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_reg <= pocp_pkg::FAULT_NONE;
        end else if (advance) begin
            fault_reg <= fault_next;
        end
    end

    always_comb begin
        out_data_next.trip_now    = phase.instant_trip || win.rms_trip;
        out_data_next.fault_code  = fault_next;
        out_data_next.rms_u       = win.rms_u;
        out_data_next.rms_v       = win.rms_v;
        out_data_next.rms_w       = win.rms_w;
        out_data_next.rms_updated = win.updated;
        out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[hdl/pocp_phase_front.sv]
`timescale 1ns / 1ps

module pocp_phase_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  pocp_pkg::sample_t             sample,
    input  logic [pocp_pkg::InstW-1:0]    instant_limit,
    output pocp_pkg::phase_t              phase
);

    logic signed [pocp_pkg::SampleW-1:0] offset_u_reg, offset_u_next;
    logic signed [pocp_pkg::SampleW-1:0] offset_w_reg, offset_w_next;
    logic signed [pocp_pkg::SampleW:0]   diff_u, diff_w;
    logic signed [pocp_pkg::SampleW+1:0] diff_v;
    logic [pocp_pkg::MagW-1:0]           lim;

    // Capture first, so a stopped sample sees zero differences
    always_comb begin
        offset_u_next = sample.motor_stopped ? sample.phase_u_mv : offset_u_reg;
        offset_w_next = sample.motor_stopped ? sample.phase_w_mv : offset_w_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_u_reg <= '0;
            offset_w_reg <= '0;
        end else if (advance) begin
            offset_u_reg <= offset_u_next;
            offset_w_reg <= offset_w_next;
        end
    end

    always_comb begin
        diff_u = {sample.phase_u_mv[pocp_pkg::SampleW-1], sample.phase_u_mv}
               - {offset_u_next[pocp_pkg::SampleW-1], offset_u_next};
        diff_w = {sample.phase_w_mv[pocp_pkg::SampleW-1], sample.phase_w_mv}
               - {offset_w_next[pocp_pkg::SampleW-1], offset_w_next};
        diff_v = -({diff_u[pocp_pkg::SampleW], diff_u}
                 + {diff_w[pocp_pkg::SampleW], diff_w});
        lim    = {instant_limit, 2'b00};

        phase.abs_u = diff_u[pocp_pkg::SampleW]
                    ? pocp_pkg::MagW'(-diff_u) : pocp_pkg::MagW'(diff_u);
        phase.abs_w = diff_w[pocp_pkg::SampleW]
                    ? pocp_pkg::MagW'(-diff_w) : pocp_pkg::MagW'(diff_w);
        phase.abs_v = diff_v[pocp_pkg::SampleW+1]
                    ? pocp_pkg::MagW'(-diff_v) : pocp_pkg::MagW'(diff_v);
        phase.instant_trip = (phase.abs_u > lim) || (phase.abs_v > lim)
                          || (phase.abs_w > lim);
    end

endmodule

[hdl/pocp_window_rms.sv]
`timescale 1ns / 1ps

module pocp_window_rms (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  pocp_pkg::phase_t              phase,
    input  logic [pocp_pkg::WinW-1:0]     window_samples,
    input  logic [pocp_pkg::RmsLimW-1:0]  rms_limit,
    output pocp_pkg::win_t                win
);

    logic [pocp_pkg::MagW-1:0] peak_u_reg, peak_v_reg, peak_w_reg;
    logic [pocp_pkg::MagW-1:0] peak_u_next, peak_v_next, peak_w_next;
    logic [pocp_pkg::MagW-1:0] peak_u_max, peak_v_max, peak_w_max;
    logic [pocp_pkg::WinW-1:0] count_reg, count_next, count_inc, win_len;
    logic [pocp_pkg::RmsW-1:0] rms_u_reg, rms_v_reg, rms_w_reg;
    logic [pocp_pkg::RmsW-1:0] rms_u_next, rms_v_next, rms_w_next;
    logic                      close;

    always_comb begin
        peak_u_max = (phase.abs_u > peak_u_reg) ? phase.abs_u : peak_u_reg;
        peak_v_max = (phase.abs_v > peak_v_reg) ? phase.abs_v : peak_v_reg;
        peak_w_max = (phase.abs_w > peak_w_reg) ? phase.abs_w : peak_w_reg;

        // A zero window length behaves as one
        win_len   = (window_samples == '0) ? pocp_pkg::WinW'(1) : window_samples;
        count_inc = count_reg + pocp_pkg::WinW'(1);
        close     = (count_inc >= win_len);

        count_next  = close ? '0 : count_inc;
        peak_u_next = close ? '0 : peak_u_max;
        peak_v_next = close ? '0 : peak_v_max;
        peak_w_next = close ? '0 : peak_w_max;
        rms_u_next  = close ? pocp_pkg::rms_of(peak_u_max) : rms_u_reg;
        rms_v_next  = close ? pocp_pkg::rms_of(peak_v_max) : rms_v_reg;
        rms_w_next  = close ? pocp_pkg::rms_of(peak_w_max) : rms_w_reg;

        win.rms_u    = rms_u_next;
        win.rms_v    = rms_v_next;
        win.rms_w    = rms_w_next;
        win.updated  = close;
        win.rms_trip = close
            && ((pocp_pkg::RmsLimW'(rms_u_next) > rms_limit)
             || (pocp_pkg::RmsLimW'(rms_v_next) > rms_limit)
             || (pocp_pkg::RmsLimW'(rms_w_next) > rms_limit));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_u_reg <= '0;
            peak_v_reg <= '0;
            peak_w_reg <= '0;
            count_reg  <= '0;
            rms_u_reg  <= '0;
            rms_v_reg  <= '0;
            rms_w_reg  <= '0;
        end else if (advance) begin
            peak_u_reg <= peak_u_next;
            peak_v_reg <= peak_v_next;
            peak_w_reg <= peak_w_next;
            count_reg  <= count_next;
            rms_u_reg  <= rms_u_next;
            rms_v_reg  <= rms_v_next;
            rms_w_reg  <= rms_w_next;
        end
    end

endmodule

[dv/phase_overcurrent_protector_unit_tb.sv]
`timescale 1ns / 1ps

module phase_overcurrent_protector_unit_tb;

    // Run shape
    localparam int RANDOM_SAMPLES = 930;
    localparam int QUIET_TAIL     = 120;     // last samples run with no idling at all
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 8;

    // Sensor full scale of a 14-bit two's complement reading
    localparam int MV_MAX = 8191;
    localparam int MV_MIN = -8192;

    // Peak to rms scale: peak * 0.25 / 1.414 as a Q16 multiply, clamped to 12 bits
    localparam longint unsigned RMS_NUM  = 11587;
    localparam int              RMS_FRAC = 16;
    localparam int unsigned     RMS_CEIL = 4095;

    // Index with no register behind it; writes there must change nothing
    localparam logic [pocp_pkg::CfgIdxW-1:0] REG_SPARE = 2'd3;

    typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    // One step of the directed sequence: a register write or a sample,
    // optionally with a hand-written expected result.
    typedef struct {
        row_kind_t                     kind;
        logic [pocp_pkg::CfgIdxW-1:0]  reg_idx;
        logic [pocp_pkg::CfgW-1:0]     reg_val;
        pocp_pkg::sample_t             smp;
        bit                            typed;
        pocp_pkg::result_t             want;
    } plan_row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [pocp_pkg::InDataW-1:0]    s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [pocp_pkg::OutDataW-1:0]   m_axis_tdata;
    logic                            cfg_we;
    logic [pocp_pkg::CfgIdxW-1:0]    cfg_index;
    logic [pocp_pkg::CfgW-1:0]       cfg_wdata;

    // Model state: zero offsets, running peaks, window position, rms values, held fault
    int                              zero_u = 0;
    int                              zero_w = 0;
    int unsigned                     pk[3] = '{0, 0, 0};
    int unsigned                     win_cnt = 0;
    logic [pocp_pkg::RmsW-1:0]       rms_est[3] = '{'0, '0, '0};
    logic [pocp_pkg::FaultW-1:0]     fault_held = pocp_pkg::FAULT_NONE;

    // Model copy of the registers, starting at their reset values
    int unsigned           lim_rms  = pocp_pkg::RMS_LIMIT_RST;
    int unsigned           lim_inst = pocp_pkg::INSTANT_LIMIT_RST;
    int unsigned           win_len  = pocp_pkg::WINDOW_RST;

    pocp_pkg::result_t     results_due[$];

    // Idle pressure in percent: burst chance per sample (gap) or per cycle (stall)
    int unsigned           gap_pct   = 0;
    int unsigned           stall_pct = 0;

    int                    mismatches     = 0;
    int                    samples_sent   = 0;
    int                    reg_writes     = 0;
    int                    windows_closed = 0;
    int                    trips_flagged  = 0;
    int                    cycle_cnt      = 0;

    phase_overcurrent_protector_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [13:0] phase_u_mv, [27:14] phase_w_mv, [28] motor_stopped, [31:29] zero
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [0] trip_now, [2:1] fault_code, [14:3] rms_u, [26:15] rms_v,
        // [38:27] rms_w, [39] rms_updated
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still due",
                     $time, cycle_cnt, results_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Scale a peak magnitude to an rms estimate, clamping at 12-bit full scale
    function automatic logic [pocp_pkg::RmsW-1:0] scale_peak(input int unsigned peak);
        longint unsigned prod;
        prod = (longint'(peak) * RMS_NUM) >> RMS_FRAC;
        if (prod > RMS_CEIL) begin
            return pocp_pkg::RmsW'(RMS_CEIL);
        end
        return pocp_pkg::RmsW'(prod);
    endfunction

    // Advance the protection model by one sample and return the result it owes
    function automatic pocp_pkg::result_t predict_protection(input pocp_pkg::sample_t smp);
        int                su;
        int                sw;
        int                d[3];
        int unsigned       mag[3];
        int unsigned       win;
        bit                inst_hit;
        bit                rms_hit;
        pocp_pkg::result_t r;
        su       = $signed(smp.phase_u_mv);
        sw       = $signed(smp.phase_w_mv);
        inst_hit = 1'b0;
        rms_hit  = 1'b0;
        r        = '0;

        // Capture comes first, so a capturing sample sees zero differences
        if (smp.motor_stopped) begin
            zero_u = su;
            zero_w = sw;
        end
        d[0] = su - zero_u;
        d[2] = sw - zero_w;
        d[1] = -d[0] - d[2];   // V from the other two phases

        for (int p = 0; p < 3; p++) begin
            mag[p] = (d[p] < 0) ? -d[p] : d[p];
            // current = diff / 4, so compare the raw magnitude against 4x the limit
            if (mag[p] > 4 * lim_inst) begin
                inst_hit = 1'b1;
            end
            if (mag[p] > pk[p]) begin
                pk[p] = mag[p];
            end
        end
        if (inst_hit) begin
            fault_held = pocp_pkg::FAULT_INSTANT;
        end

        // A zero window length behaves as one; a shrunk window closes at once
        win     = (win_len == 0) ? 1 : win_len;
        win_cnt = (win_cnt + 1) % (1 << pocp_pkg::WinW);
        if (win_cnt >= win) begin
            win_cnt = 0;
            r.rms_updated = 1'b1;
            windows_closed++;
            for (int p = 0; p < 3; p++) begin
                rms_est[p] = scale_peak(pk[p]);
                pk[p]      = 0;
                if (rms_est[p] > lim_rms) begin
                    rms_hit = 1'b1;
                end
            end
            // rms trip lands after the instant one, so its code wins
            if (rms_hit) begin
                fault_held = pocp_pkg::FAULT_RMS;
            end
        end

        r.trip_now   = inst_hit | rms_hit;
        r.fault_code = fault_held;
        r.rms_u      = rms_est[0];
        r.rms_v      = rms_est[1];
        r.rms_w      = rms_est[2];
        if (r.trip_now) begin
            trips_flagged++;
        end
        return r;
    endfunction

    function automatic pocp_pkg::sample_t make_sample(input int u, input int w,
                                                      input bit stopped);
        pocp_pkg::sample_t s;
        s.phase_u_mv    = u[pocp_pkg::SampleW-1:0];
        s.phase_w_mv    = w[pocp_pkg::SampleW-1:0];
        s.motor_stopped = stopped;
        return s;
    endfunction

    function automatic int clip_mv(input int v);
        if (v > MV_MAX) begin
            return MV_MAX;
        end
        if (v < MV_MIN) begin
            return MV_MIN;
        end
        return v;
    endfunction

    function automatic plan_row_t row_sample(input int u, input int w, input bit stopped);
        plan_row_t row;
        row.kind    = ROW_SAMPLE;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.smp     = make_sample(u, w, stopped);
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic plan_row_t row_typed(input int u, input int w, input bit stopped,
                                            input bit trip,
                                            input logic [pocp_pkg::FaultW-1:0] fault,
                                            input int unsigned ru, input int unsigned rv,
                                            input int unsigned rw, input bit upd);
        plan_row_t row;
        row                  = row_sample(u, w, stopped);
        row.typed            = 1'b1;
        row.want.trip_now    = trip;
        row.want.fault_code  = fault;
        row.want.rms_u       = ru[pocp_pkg::RmsW-1:0];
        row.want.rms_v       = rv[pocp_pkg::RmsW-1:0];
        row.want.rms_w       = rw[pocp_pkg::RmsW-1:0];
        row.want.rms_updated = upd;
        return row;
    endfunction

    function automatic plan_row_t row_write(input logic [pocp_pkg::CfgIdxW-1:0] idx,
                                            input logic [pocp_pkg::CfgW-1:0] val);
        plan_row_t row;
        row         = row_sample(0, 0, 1'b0);
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Drop tvalid and hold until every due result has come back
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Register writes happen only with the block idle, so drain first
    task automatic write_reg(input logic [pocp_pkg::CfgIdxW-1:0] idx,
                             input logic [pocp_pkg::CfgW-1:0] val);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        case (idx)
            pocp_pkg::REG_RMS_LIMIT:     lim_rms  = val;
            pocp_pkg::REG_INSTANT_LIMIT: lim_inst = val[pocp_pkg::InstW-1:0];
            pocp_pkg::REG_WINDOW:        win_len  = val[pocp_pkg::WinW-1:0];
            default: ;         // no register there
        endcase
        reg_writes++;
    endtask

    // Offer one sample, possibly after an idle burst; on the transfer edge advance the
    // model and queue the result owed (the typed one where a row supplies it)
    task automatic send_sample(input pocp_pkg::sample_t smp, input bit typed,
                               input pocp_pkg::result_t want);
        pocp_pkg::result_t due;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(pocp_pkg::InDataW - $bits(pocp_pkg::sample_t)){1'b0}}, smp};
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        due = predict_protection(smp);
        results_due.push_back(typed ? want : due);
        samples_sent++;
    endtask

    // Result sink: tready low in random bursts while stall_pct is nonzero
    initial begin : result_sink
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                hold_left = $urandom_range(5);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Result check: every m_axis transfer must match the oldest due result
    always @(posedge aclk) begin : result_check
        pocp_pkg::result_t got;
        pocp_pkg::result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = pocp_pkg::result_t'(m_axis_tdata);
            if (results_due.size() == 0) begin
                $display("%0t: result transfer with nothing due, expected none, got %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("trip_now",    want.trip_now,    got.trip_now);
                check_field("fault_code",  want.fault_code,  got.fault_code);
                check_field("rms_u",       want.rms_u,       got.rms_u);
                check_field("rms_v",       want.rms_v,       got.rms_v);
                check_field("rms_w",       want.rms_w,       got.rms_w);
                check_field("rms_updated", want.rms_updated, got.rms_updated);
            end
        end
    end

    initial begin : stimulus
        plan_row_t                 plan[$];
        logic [pocp_pkg::CfgW-1:0] reg_val;
        int                        u;
        int                        w;
        int                        roll;
        int                        amp;
        int                        base_u;
        int                        base_w;
        int                        random_left;
        int                        phase_len;
        bit                        stopped;
        bit                        first_phase;
        bit                        capture_first;

        // Hold every input at a known value and keep reset low
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sequence. Starts at reset values: rms limit 0, instant limit 200
        // (800 mV of raw difference), window 300.
        plan.push_back(row_typed(0, 0, 1'b0, 1'b0, pocp_pkg::FAULT_NONE, 0, 0, 0, 1'b0));
        // capture and compute in one sample: differences come out zero
        plan.push_back(row_typed(100, -50, 1'b1, 1'b0, pocp_pkg::FAULT_NONE,
                                 0, 0, 0, 1'b0));
        // exactly at the instant limit: no trip
        plan.push_back(row_typed(900, -50, 1'b0, 1'b0, pocp_pkg::FAULT_NONE,
                                 0, 0, 0, 1'b0));
        // one past it: instant trip, code latches
        plan.push_back(row_typed(901, -50, 1'b0, 1'b1, pocp_pkg::FAULT_INSTANT,
                                 0, 0, 0, 1'b0));
        plan.push_back(row_typed(100, -50, 1'b0, 1'b0, pocp_pkg::FAULT_INSTANT,
                                 0, 0, 0, 1'b0));
        // window cut below the running count: the next sample closes it
        plan.push_back(row_write(pocp_pkg::REG_WINDOW, 16'd1));
        plan.push_back(row_write(pocp_pkg::REG_RMS_LIMIT, 16'hFFFF));
        plan.push_back(row_sample(100, -50, 1'b0));
        // sensor extremes, both polarities
        plan.push_back(row_sample(MV_MAX, MV_MIN, 1'b0));
        plan.push_back(row_sample(MV_MIN, MV_MAX, 1'b0));
        plan.push_back(row_typed(MV_MIN, MV_MIN, 1'b1, 1'b0, pocp_pkg::FAULT_INSTANT,
                                 0, 0, 0, 1'b1));
        // largest possible differences: V saturates the rms estimate
        plan.push_back(row_sample(MV_MAX, MV_MAX, 1'b0));
        // rms trip alone overwrites the instant code
        plan.push_back(row_write(pocp_pkg::REG_INSTANT_LIMIT, 16'd5000));
        plan.push_back(row_write(pocp_pkg::REG_RMS_LIMIT, 16'd0));
        plan.push_back(row_typed(-7192, MV_MIN, 1'b0, 1'b1, pocp_pkg::FAULT_RMS,
                                 176, 176, 0, 1'b1));
        // both trips in one sample: rms code is applied last and stays
        plan.push_back(row_write(pocp_pkg::REG_INSTANT_LIMIT, 16'd0));
        plan.push_back(row_typed(-8186, MV_MIN, 1'b0, 1'b1, pocp_pkg::FAULT_RMS,
                                 1, 1, 0, 1'b1));
        // instant trip alone overwrites the rms code
        plan.push_back(row_typed(-8190, MV_MIN, 1'b0, 1'b1, pocp_pkg::FAULT_INSTANT,
                                 0, 0, 0, 1'b1));
        // window length zero acts as one; the unused index must change nothing
        plan.push_back(row_write(pocp_pkg::REG_WINDOW, 16'd0));
        plan.push_back(row_write(REG_SPARE, 16'hFFFF));
        plan.push_back(row_write(pocp_pkg::REG_INSTANT_LIMIT, 16'd5000));
        plan.push_back(row_write(pocp_pkg::REG_RMS_LIMIT, 16'hFFFF));
        plan.push_back(row_typed(MV_MIN, MV_MIN, 1'b0, 1'b0, pocp_pkg::FAULT_INSTANT,
                                 0, 0, 0, 1'b1));
        // shrink a longer window mid-count
        plan.push_back(row_write(pocp_pkg::REG_WINDOW, 16'd10));
        plan.push_back(row_sample(0, 0, 1'b0));
        plan.push_back(row_sample(100, 200, 1'b0));
        plan.push_back(row_sample(-300, 50, 1'b0));
        plan.push_back(row_sample(1, 1, 1'b1));
        plan.push_back(row_write(pocp_pkg::REG_WINDOW, 16'd2));
        plan.push_back(row_sample(-100, 300, 1'b0));

        gap_pct   = 20;
        stall_pct = 20;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_sample(plan[i].smp, plan[i].typed, plan[i].want);
            end
        end

        // Random phases. Each phase retunes some registers (write_reg drains first, so
        // the sender holds until every due result is back), picks its own idle pressure
        // and signal swing, then runs a motor: an optional offset capture followed by
        // samples around the offsets, with some raw noise and recaptures mixed in.
        random_left = RANDOM_SAMPLES;
        first_phase = 1'b1;
        base_u      = 0;
        base_w      = 0;
        while (random_left > 0) begin
            phase_len = $urandom_range(160, 60);
            if (phase_len > random_left) begin
                phase_len = random_left;
            end

            if (first_phase || $urandom_range(99) < 60) begin
                case ($urandom_range(3))
                    0:       reg_val = 16'd0;
                    1:       reg_val = 16'hFFFF;
                    2:       reg_val = pocp_pkg::CfgW'($urandom_range(4095));
                    default: reg_val = pocp_pkg::CfgW'($urandom_range(400));
                endcase
                write_reg(pocp_pkg::REG_RMS_LIMIT, reg_val);
            end
            if (first_phase || $urandom_range(99) < 60) begin
                case ($urandom_range(3))
                    0:       reg_val = 16'd0;
                    1:       reg_val = 16'd5000;
                    default: reg_val = pocp_pkg::CfgW'($urandom_range(5000));
                endcase
                write_reg(pocp_pkg::REG_INSTANT_LIMIT, reg_val);
            end
            if (first_phase || $urandom_range(99) < 60) begin
                case ($urandom_range(7))
                    0:       reg_val = 16'd1;
                    1:       reg_val = 16'd1023;
                    2:       reg_val = 16'd0;
                    3:       reg_val = 16'd300;
                    default: reg_val = pocp_pkg::CfgW'($urandom_range(40, 1));
                endcase
                write_reg(pocp_pkg::REG_WINDOW, reg_val);
            end
            if ($urandom_range(99) < 10) begin
                write_reg(REG_SPARE, pocp_pkg::CfgW'($urandom_range(16'hFFFF)));
            end
            first_phase = 1'b0;

            case ($urandom_range(2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(2))
                0:       stall_pct = 0;
                1:       stall_pct = 15;
                default: stall_pct = 40;
            endcase
            case ($urandom_range(3))
                0:       amp = 120;
                1:       amp = 1200;
                2:       amp = 5000;
                default: amp = 16383;
            endcase
            capture_first = 1'($urandom_range(1));

            for (int k = 0; k < phase_len; k++) begin
                if (random_left <= QUIET_TAIL) begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                roll = $urandom_range(99);
                if ((k == 0 && capture_first) || roll < 4) begin
                    // motor at rest: new zero offsets near mid-scale
                    base_u  = int'($urandom_range(800)) - 400;
                    base_w  = int'($urandom_range(800)) - 400;
                    u       = base_u;
                    w       = base_w;
                    stopped = 1'b1;
                end else if (roll < 14) begin
                    // raw noise over the whole 14-bit pattern space
                    u       = int'($urandom_range(16383)) + MV_MIN;
                    w       = int'($urandom_range(16383)) + MV_MIN;
                    stopped = ($urandom_range(7) == 0);
                end else begin
                    u       = clip_mv(base_u + int'($urandom_range(2 * amp)) - amp);
                    w       = clip_mv(base_w + int'($urandom_range(2 * amp)) - amp);
                    stopped = 1'b0;
                end
                send_sample(make_sample(u, w, stopped), 1'b0, '0);
                random_left--;
            end
        end

        // Drain, then let the pipeline settle so any stray result shows up
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d samples and %0d register writes in %0d cycles",
                 samples_sent, reg_writes, cycle_cnt);
        $display("windows closed: %0d, trips flagged: %0d, mismatches: %0d",
                 windows_closed, trips_flagged, mismatches);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[phase_overcurrent_protector_unit.f]
hdl/pocp_pkg.sv
hdl/pocp_phase_front.sv
hdl/pocp_window_rms.sv
hdl/phase_overcurrent_protector_unit.sv
dv/phase_overcurrent_protector_unit_tb.sv
